### rtl/sra_pkg.sv
// Shared constants and types for the scalar rank assigner.
package sra_pkg;

    localparam int MAX_VALUES  = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(MAX_VALUES);
    localparam int CNT_W       = $clog2(MAX_VALUES + 1);
    localparam int RANK_W      = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ASCENDING      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_FROM_ONE = 2'd1;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_FETCH = 5'b00010,
        S_LATCH = 5'b00100,
        S_SCAN  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

endpackage

### rtl/sra_channels.sv
// Valid/ready channel interfaces for the input items and the rank results.
interface sra_in_if
    import sra_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] sample_value;
    logic                          is_last;

    modport source (output valid, sample_value, is_last, input ready);
    modport sink   (input valid, sample_value, is_last, output ready);
endinterface

interface sra_out_if
    import sra_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank;
    logic              last_rank;

    modport source (output valid, rank, last_rank, input ready);
    modport sink   (input valid, rank, last_rank, output ready);
endinterface

### rtl/sra_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/scalar_rank_assigner_unit.sv
// Scalar rank assigner: collects a set of signed values and returns their sorted ranks.
//
// Values arrive one item at a time and are written to a 64-entry value RAM; an item
// carrying is_last closes the set (items beyond 64 are dropped, but their last flag
// still closes the set). While loading, an item is accepted whenever one is offered.
// The block then returns one rank per stored value, in arrival order. Ties are ranked
// by arrival order. Each rank is found by reading its own value and then scanning all
// n stored values through the single RAM read port, one per cycle. No new item is
// taken until the last rank has been handed to the output register. The ascending and
// count_from_one settings are sampled when the last item is accepted.
module scalar_rank_assigner_unit
    import sra_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sra_in_if.sink                i_item,
    sra_out_if.source             o_rank
);
    t_state r_state, n_state;

    logic                          r_cfg_asc;
    logic                          r_cfg_cfo;
    logic                          r_asc;
    logic                          r_cfo;
    logic [CNT_W-1:0]              r_count;
    logic [ADDR_W-1:0]             r_last_idx;
    logic [ADDR_W-1:0]             r_i;
    logic [ADDR_W-1:0]             r_j;
    logic [ADDR_W-1:0]             r_pj;
    logic                          r_pend;
    logic                          r_issued;
    logic [CNT_W-1:0]              r_acc;
    logic signed [VALUE_WIDTH-1:0] r_vi;
    logic                          r_out_valid;
    logic [RANK_W-1:0]             r_out_rank;
    logic                          r_out_last;

    logic                          w_accept;
    logic                          w_room;
    logic                          w_we;
    logic [ADDR_W-1:0]             w_raddr;
    logic [VALUE_WIDTH-1:0]        w_rdata;
    logic signed [VALUE_WIDTH-1:0] w_vj;
    logic                          w_before;
    logic                          w_out_free;
    logic                          w_emit;

    assign w_accept   = i_item.valid && i_item.ready;
    assign w_room     = r_count < CNT_W'(MAX_VALUES);
    assign w_we       = w_accept && w_room;
    assign w_raddr    = (r_state == S_FETCH) ? r_i : r_j;
    assign w_vj       = $signed(w_rdata);
    assign w_out_free = !r_out_valid || o_rank.ready;
    assign w_emit     = (r_state == S_EMIT) && w_out_free;

    sra_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_VALUES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_item.sample_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Equal values count as earlier only when they arrived before this one.
    always_comb begin
        if (w_vj == r_vi) begin
            w_before = r_pj < r_i;
        end else if (r_asc) begin
            w_before = w_vj < r_vi;
        end else begin
            w_before = w_vj > r_vi;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_accept && i_item.is_last) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: n_state = S_LATCH;
            S_LATCH: n_state = S_SCAN;
            S_SCAN: begin
                if (r_issued && r_pend) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = (r_i == r_last_idx) ? S_LOAD : S_FETCH;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cfg_asc   <= 1'b1;
            r_cfg_cfo   <= 1'b0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ASCENDING:      r_cfg_asc <= i_cfg_data[0];
                    CFG_COUNT_FROM_ONE: r_cfg_cfo <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rank.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_item.is_last) begin
                            r_asc      <= r_cfg_asc;
                            r_cfo      <= r_cfg_cfo;
                            r_last_idx <= w_room ? r_count[ADDR_W-1:0]
                                                 : ADDR_W'(MAX_VALUES - 1);
                            r_i        <= '0;
                        end
                    end
                end
                S_FETCH: ;
                S_LATCH: begin
                    r_vi     <= $signed(w_rdata);
                    r_j      <= '0;
                    r_acc    <= '0;
                    r_pend   <= 1'b0;
                    r_issued <= 1'b0;
                end
                S_SCAN: begin
                    // Read of r_j is issued now; its data is compared next cycle.
                    if (!r_issued) begin
                        r_pj   <= r_j;
                        r_pend <= 1'b1;
                        if (r_j == r_last_idx) begin
                            r_issued <= 1'b1;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend && w_before) begin
                        r_acc <= r_acc + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_rank  <= RANK_W'(r_acc) + RANK_W'(r_cfo);
                        r_out_last  <= r_i == r_last_idx;
                        if (r_i == r_last_idx) begin
                            r_count <= '0;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign i_item.ready     = r_state == S_LOAD;
    assign o_rank.valid     = r_out_valid;
    assign o_rank.rank      = r_out_rank;
    assign o_rank.last_rank = r_out_last;

    // The fill count never runs past the store.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VALUES))
        else $error("value count exceeds store depth");

    // Closing a set stops intake until its ranks are out.
    a_close_stops_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.is_last) |=> !i_item.ready)
        else $error("item accepted while ranks are being computed");

    // The count of earlier values can never exceed the index of the last stored value.
    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_acc <= CNT_W'(r_last_idx)))
        else $error("rank count out of range");

    // After the final rank of a set is emitted, the block returns to loading.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free && r_i == r_last_idx) |=> r_state == S_LOAD)
        else $error("set did not close after its final rank");
endmodule

### verif/sra_rank_checker.sv
// Rank checker: follows both channels, predicts the rank of every stored value and compares.
module sra_rank_checker
    import sra_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_in_value,
    input  logic                          i_in_last,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [RANK_W-1:0]             i_out_rank,
    input  logic                          i_out_last_rank,
    output int                            o_mismatches,
    output int                            o_pending
);

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              last_rank;
    } t_rank_result;

    t_rank_result                  expected_ranks[$];
    logic signed [VALUE_WIDTH-1:0] set_values[MAX_VALUES];
    int                            set_count       = 0;
    logic                          order_ascending = 1'b1;
    logic                          rank_from_one   = 1'b0;
    int                            mismatches      = 0;

    // Ranks the stored values of the closed set; equal values go by arrival order.
    function automatic void predict_set_ranks();
        int           r;
        logic         ahead;
        t_rank_result res;
        for (int i = 0; i < set_count; i++) begin
            r = 0;
            for (int j = 0; j < set_count; j++) begin
                if (set_values[j] == set_values[i]) begin
                    ahead = (j < i);
                end else if (order_ascending) begin
                    ahead = (set_values[j] < set_values[i]);
                end else begin
                    ahead = (set_values[j] > set_values[i]);
                end
                if (ahead) r++;
            end
            if (rank_from_one) r++;
            res.rank      = r[RANK_W-1:0];
            res.last_rank = (i == set_count - 1);
            expected_ranks.push_back(res);
        end
    endfunction

    always @(posedge i_clk) begin
        t_rank_result got;
        t_rank_result want;
        if (!i_rst_n) begin
            expected_ranks.delete();
            set_count       = 0;
            order_ascending = 1'b1;
            rank_from_one   = 1'b0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.rank      = i_out_rank;
                got.last_rank = i_out_last_rank;
                if (expected_ranks.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected rank item: rank %0d last_rank %0b",
                                 got.rank, got.last_rank);
                    mismatches++;
                end else begin
                    want = expected_ranks.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display("rank mismatch: expected rank %0d last_rank %0b, got rank %0d last_rank %0b",
                                     want.rank, want.last_rank, got.rank, got.last_rank);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                // Values beyond the store are dropped, but their last flag still closes the set.
                if (set_count < MAX_VALUES) begin
                    set_values[set_count] = i_in_value;
                    set_count++;
                end
                if (i_in_last) begin
                    predict_set_ranks();
                    set_count = 0;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ASCENDING:      order_ascending = i_cfg_data[0];
                    CFG_COUNT_FROM_ONE: rank_from_one   = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_pending    = expected_ranks.size();
        o_mismatches = mismatches;
    end

endmodule

### verif/tb_scalar_rank_assigner_unit.sv
// Testbench top for the scalar rank assigner: clock, reset, stimulus, stalls and verdict.
module tb_scalar_rank_assigner_unit;
    import sra_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 330;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [CFG_IDX_W-1:0]          CFG_UNUSED_IDX = 2'd3;
    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  tx_idle_en;
    logic                  rx_stall_en;
    int                    mismatches;
    int                    pending;
    int                    cycles;
    int                    items_sent;

    sra_in_if  in_ch();
    sra_out_if out_ch();

    scalar_rank_assigner_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (in_ch),
        .o_rank     (out_ch)
    );

    sra_rank_checker u_rank_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_ch.valid),
        .i_in_ready      (in_ch.ready),
        .i_in_value      (in_ch.sample_value),
        .i_in_last       (in_ch.is_last),
        .i_out_valid     (out_ch.valid),
        .i_out_ready     (out_ch.ready),
        .i_out_rank      (out_ch.rank),
        .i_out_last_rank (out_ch.last_rank),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("scalar_rank_assigner_unit verification failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 12);
        return $urandom_range(30, 150);
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 99);
        // Narrow values make ties common.
        if (pick < 25) return int'($urandom_range(0, 8)) - 4;
        if (pick < 40) begin
            case ($urandom_range(0, 5))
                0:       return VALUE_MIN;
                1:       return VALUE_MAX;
                2:       return VALUE_MIN + 1;
                3:       return VALUE_MAX - 1;
                4:       return 0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    // Most sets are short; a few fill the store or run past it.
    function automatic int set_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return $urandom_range(1, 8);
        if (pick < 90) return $urandom_range(9, 24);
        if (pick < 96) return $urandom_range(60, MAX_VALUES);
        return $urandom_range(MAX_VALUES + 1, MAX_VALUES + 6);
    endfunction

    task automatic send_item(input logic signed [VALUE_WIDTH-1:0] value, input logic last);
        int gap;
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.sample_value <= value;
        in_ch.is_last      <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        gap = tx_idle_en ? idle_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid        <= 1'b0;
            in_ch.sample_value <= $urandom;
            in_ch.is_last      <= 1'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Holds the sender until every predicted rank has come back, then lets the block settle.
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(input logic asc, input logic from_one);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        cfg_we      <= 1'b1;
        cfg_idx     <= CFG_ASCENDING;
        cfg_data    <= asc;
        @(negedge i_clk);
        cfg_idx     <= CFG_COUNT_FROM_ONE;
        cfg_data    <= from_one;
        @(negedge i_clk);
        // A write to an index with no register behind it must change nothing.
        cfg_idx     <= CFG_UNUSED_IDX;
        cfg_data    <= CFG_DATA_W'($urandom);
        @(negedge i_clk);
        cfg_we      <= 1'b0;
    endtask

    initial begin
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
            if (rx_stall_en) begin
                int gap;
                gap = idle_len();
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
    end

    initial begin
        int len;
        in_ch.valid        = 1'b0;
        in_ch.sample_value = '0;
        in_ch.is_last      = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_ASCENDING;
        cfg_data           = '0;
        tx_idle_en         = 1'b0;
        rx_stall_en        = 1'b0;
        items_sent         = 0;
        i_rst_n            = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Settings after reset: ascending, counting from zero.
        send_item(VALUE_MIN, 1'b1);
        send_item(VALUE_MAX, 1'b0);
        send_item(VALUE_MIN, 1'b0);
        send_item(0, 1'b0);
        send_item(-1, 1'b0);
        send_item(1, 1'b0);
        send_item(VALUE_MIN, 1'b0);
        send_item(VALUE_MAX, 1'b1);
        wait_idle();

        set_config(1'b0, 1'b1);
        send_item(5, 1'b0);
        send_item(5, 1'b0);
        send_item(5, 1'b1);
        send_item(VALUE_MIN, 1'b0);
        send_item(VALUE_MAX, 1'b0);
        send_item(-1, 1'b0);
        send_item(0, 1'b1);
        wait_idle();

        set_config(1'b1, 1'b1);
        send_item(7, 1'b0);
        send_item(-7, 1'b0);
        send_item(7, 1'b0);
        send_item(0, 1'b1);
        wait_idle();

        set_config(1'b0, 1'b0);
        send_item(3, 1'b0);
        send_item(1, 1'b0);
        send_item(2, 1'b0);
        send_item(2, 1'b1);
        wait_idle();

        while (items_sent < RANDOM_ITEMS) begin
            set_config(1'($urandom), 1'($urandom));
            tx_idle_en  = ($urandom_range(0, 9) < 7);
            rx_stall_en = ($urandom_range(0, 9) < 7);
            repeat ($urandom_range(1, 4)) begin
                len = set_length();
                for (int k = 0; k < len; k++)
                    send_item(random_value(), k == len - 1);
                items_sent += len;
            end
            wait_idle();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("scalar_rank_assigner_unit verification clean");
        end else begin
            $display("scalar_rank_assigner_unit verification failed");
        end
        $finish;
    end

endmodule
